@@ design/ple_pkg.sv @@
// ple_pkg: shared constants, operation and status codes, controller/datapath structs
// for the positional list engine; no dependencies
package ple_pkg;

	localparam int FUNC_W = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;
	localparam int CHUNK  = 8;
	localparam int PART_W = 4;

	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
	} ple_cmd_t;

	typedef struct packed {
		logic need_scan;
		logic last_chunk;
	} ple_stat_t;

endpackage

@@ design/ple_datapath.sv @@
// ple_datapath: list cells with parallel shift, length counter, per-chunk match
// counts and result registers; depends on ple_pkg
module ple_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ple_pkg::ple_cmd_t                   cmd,
	output ple_pkg::ple_stat_t                  stat,
	input  logic [ple_pkg::FUNC_W-1:0]          func,
	input  logic signed [ple_pkg::VAL_W-1:0]    value,
	input  logic [ple_pkg::POS_W-1:0]           position,
	output logic [ple_pkg::STAT_W-1:0]          status,
	output logic signed [ple_pkg::VAL_W-1:0]    removed_value,
	output logic [ple_pkg::CNT_W-1:0]           match_count,
	output logic [ple_pkg::CNT_W-1:0]           length
);
	import ple_pkg::*;

	localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int EW     = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int XW     = (CW > CNT_W) ? CW : CNT_W;
	localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
	localparam int CIW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

	logic signed [VAL_W-1:0] cells [DEPTH];
	logic [CW-1:0]           occ_q;
	logic [FUNC_W-1:0]       func_q;
	logic signed [VAL_W-1:0] val_q;
	logic [POS_W-1:0]        pos_q;
	logic [PART_W-1:0]       part_q [NCHUNK];
	logic [PART_W-1:0]       part_d [NCHUNK];
	logic [NCHUNK*CHUNK-1:0] hit;
	logic [CIW-1:0]          cidx_q;
	logic [CW-1:0]           acc_q;
	logic [CW-1:0]           acc_nx;
	logic [STAT_W-1:0]       res_status_q;
	logic signed [VAL_W-1:0] res_removed_q;
	logic [CW-1:0]           res_match_q;
	logic [STAT_W-1:0]       ex_status;
	logic                    do_ins;
	logic                    do_del;
	logic [IW-1:0]           at;
	logic                    need_scan;
	logic [EW-1:0]           pos_e;
	logic [EW-1:0]           occ_e;
	logic [XW-1:0]           len_x;
	logic [XW-1:0]           match_x;

	// per-cell match against the incoming key, masked by occupancy
	for (genvar g = 0; g < NCHUNK * CHUNK; g++) begin : g_hit
		if (g < DEPTH) begin : g_real
			assign hit[g] = (cells[g] == value) && (CW'(g) < occ_q);
		end else begin : g_pad
			assign hit[g] = 1'b0;
		end
	end

	always_comb begin
		for (int c = 0; c < NCHUNK; c++) begin
			part_d[c] = '0;
			for (int j = 0; j < CHUNK; j++) begin
				part_d[c] = part_d[c] + PART_W'(hit[c*CHUNK + j]);
			end
		end
	end

	assign pos_e = EW'(pos_q);
	assign occ_e = EW'(occ_q);

	always_comb begin
		ex_status = ST_OK;
		do_ins    = 1'b0;
		do_del    = 1'b0;
		at        = '0;
		need_scan = 1'b0;
		case (func_q)
			FN_INS_FRONT, FN_INS_POS, FN_INS_BACK: begin
				if (occ_q >= CW'(DEPTH)) begin
					ex_status = ST_FULL;
				end else if (func_q == FN_INS_FRONT) begin
					do_ins = 1'b1;
				end else if (func_q == FN_INS_BACK) begin
					at     = IW'(occ_q);
					do_ins = 1'b1;
				end else if (occ_q == '0) begin
					do_ins = 1'b1;
				end else if (pos_e == '0 || pos_e > occ_e + EW'(1)) begin
					ex_status = ST_RANGE;
				end else begin
					at     = IW'(pos_e - EW'(1));
					do_ins = 1'b1;
				end
			end
			FN_DEL_FRONT, FN_DEL_POS, FN_DEL_BACK: begin
				if (occ_q == '0) begin
					ex_status = ST_EMPTY;
				end else if (func_q == FN_DEL_FRONT) begin
					do_del = 1'b1;
				end else if (func_q == FN_DEL_BACK) begin
					at     = IW'(occ_q - CW'(1));
					do_del = 1'b1;
				end else if (pos_e == '0 || pos_e > occ_e) begin
					ex_status = ST_RANGE;
				end else begin
					at     = IW'(pos_e - EW'(1));
					do_del = 1'b1;
				end
			end
			FN_SEARCH: begin
				if (occ_q == '0) begin
					ex_status = ST_EMPTY;
				end else begin
					need_scan = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign acc_nx          = acc_q + CW'(part_q[cidx_q]);
	assign stat.need_scan  = need_scan;
	assign stat.last_chunk = (cidx_q == CIW'(NCHUNK - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			cidx_q <= '0;
		end else begin
			if (cmd.exec) begin
				cidx_q <= '0;
				if (do_ins) begin
					occ_q <= occ_q + CW'(1);
				end else if (do_del) begin
					occ_q <= occ_q - CW'(1);
				end
			end
			if (cmd.scan) begin
				cidx_q <= cidx_q + CIW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			val_q  <= value;
			pos_q  <= position;
			for (int c = 0; c < NCHUNK; c++) begin
				part_q[c] <= part_d[c];
			end
		end
		if (cmd.exec) begin
			acc_q         <= '0;
			res_status_q  <= ex_status;
			res_match_q   <= '0;
			res_removed_q <= do_del ? cells[at] : '0;
			// insert opens a gap at the slot, delete closes it
			for (int k = 0; k < DEPTH; k++) begin
				if (do_ins) begin
					if (IW'(k) == at) begin
						cells[k] <= val_q;
					end else if (k > 0 && IW'(k) > at) begin
						cells[k] <= cells[(k > 0) ? k - 1 : 0];
					end
				end else if (do_del) begin
					if (k < DEPTH - 1 && IW'(k) >= at) begin
						cells[k] <= cells[(k < DEPTH - 1) ? k + 1 : k];
					end
				end
			end
		end
		if (cmd.scan) begin
			acc_q <= acc_nx;
			if (stat.last_chunk) begin
				res_status_q  <= ST_OK;
				res_match_q   <= acc_nx;
				res_removed_q <= '0;
			end
		end
	end

	assign len_x         = XW'(occ_q);
	assign match_x       = XW'(res_match_q);
	assign length        = len_x[CNT_W-1:0];
	assign match_count   = match_x[CNT_W-1:0];
	assign status        = res_status_q;
	assign removed_value = res_removed_q;

endmodule

@@ design/ple_ctrl.sv @@
// ple_ctrl: command sequencer for the positional list engine
// drives ple_datapath through ple_pkg command/status structs
module ple_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output ple_pkg::ple_cmd_t  cmd,
	input  ple_pkg::ple_stat_t stat
);
	import ple_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;

	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		cmd.scan = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.need_scan) begin
					state_d = S_SCAN;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.last_chunk) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

@@ design/positional_list_engine.sv @@
// positional_list_engine: ordered list of signed values with insert, delete and search
// top level; instantiates ple_ctrl and ple_datapath, uses ple_pkg
//
//   channel  | handshake          | transfer when      | payload
//   ---------+--------------------+--------------------+----------------------------------
//   command  | start / busy       | start && !busy     | func, value, position
//   result   | done (1-cycle)     | done               | status, removed_value,
//            |                    |                    | match_count, length
//
// inserts, deletes and no-ops capture the command, then execute, where inserts and deletes shift the cells
// search captures with per 8-cell group match counts and executes; on a non-empty list
// the group counts are then summed one per cycle in one accumulator
// reset clears the length and the sequencer; cell contents are not cleared
// the result strobe lasts one cycle, the receiver cannot stall it, and a new command
// may be taken in that cycle
module positional_list_engine #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ple_pkg::FUNC_W-1:0]       func,
	input  logic signed [ple_pkg::VAL_W-1:0] value,
	input  logic [ple_pkg::POS_W-1:0]        position,
	output logic                             done,
	output logic [ple_pkg::STAT_W-1:0]       status,
	output logic signed [ple_pkg::VAL_W-1:0] removed_value,
	output logic [ple_pkg::CNT_W-1:0]        match_count,
	output logic [ple_pkg::CNT_W-1:0]        length
);
	import ple_pkg::*;

	ple_cmd_t  cmd;
	ple_stat_t stat;

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	ple_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.value         (value),
		.position      (position),
		.status        (status),
		.removed_value (removed_value),
		.match_count   (match_count),
		.length        (length)
	);

endmodule

@@ test/tb_positional_list_engine.sv @@
// tb_positional_list_engine: self-checking bench for the positional list engine;
// directed table then weighted random commands checked against an in-bench list model
// depends on ple_pkg and positional_list_engine from the design folder
module tb_positional_list_engine;
	import ple_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int RAND_ITEMS = 1250;
	localparam logic [FUNC_W-1:0] FN_NOP = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] removed;
		logic [CNT_W-1:0]        hits;
		logic [CNT_W-1:0]        len;
	} list_result_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       op;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0]        pos;
		logic [4:0]              reps;
		logic                    fixed;
		list_result_t            res;
	} stim_row_t;

	localparam list_result_t EMPTY_RES = '{ST_EMPTY, 32'sd0, 5'd0, 5'd0};
	localparam list_result_t NO_RES    = '0;

	localparam stim_row_t DIRECTED[25] = '{
		'{FN_DEL_FRONT, 32'sd0,           5'd0,  5'd1,  1'b1, EMPTY_RES},
		'{FN_DEL_POS,   32'sd0,           5'd1,  5'd1,  1'b1, EMPTY_RES},
		'{FN_DEL_BACK,  32'sd0,           5'd0,  5'd1,  1'b1, EMPTY_RES},
		'{FN_SEARCH,    32'sd0,           5'd0,  5'd1,  1'b1, EMPTY_RES},
		'{FN_NOP,       32'sd5,           5'd3,  5'd1,  1'b1, NO_RES},
		'{FN_INS_POS,   32'sh7fffffff,    5'd31, 5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd0, 5'd1}},
		'{FN_INS_POS,   32'sd5,           5'd0,  5'd1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0, 5'd1}},
		'{FN_INS_POS,   32'sd5,           5'd3,  5'd1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0, 5'd1}},
		'{FN_INS_FRONT, 32'sh80000000,    5'd0,  5'd1,  1'b1, '{ST_OK, 32'sd0, 5'd0, 5'd2}},
		'{FN_INS_POS,   -32'sd1,          5'd3,  5'd1,  1'b0, NO_RES},
		'{FN_INS_BACK,  32'sd0,           5'd0,  5'd1,  1'b0, NO_RES},
		'{FN_SEARCH,    32'sh80000000,    5'd0,  5'd1,  1'b0, NO_RES},
		'{FN_DEL_POS,   32'sd0,           5'd0,  5'd1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0, 5'd4}},
		'{FN_DEL_POS,   32'sd0,           5'd5,  5'd1,  1'b1, '{ST_RANGE, 32'sd0, 5'd0, 5'd4}},
		'{FN_DEL_POS,   32'sd0,           5'd2,  5'd1,  1'b0, NO_RES},
		'{FN_INS_BACK,  32'sd42,          5'd0,  5'd13, 1'b0, NO_RES},
		'{FN_INS_FRONT, 32'sd1,           5'd0,  5'd1,  1'b1, '{ST_FULL, 32'sd0, 5'd0, 5'd16}},
		'{FN_INS_POS,   32'sd1,           5'd1,  5'd1,  1'b1, '{ST_FULL, 32'sd0, 5'd0, 5'd16}},
		'{FN_INS_BACK,  32'sd1,           5'd0,  5'd1,  1'b1, '{ST_FULL, 32'sd0, 5'd0, 5'd16}},
		'{FN_SEARCH,    32'sd42,          5'd0,  5'd1,  1'b0, NO_RES},
		'{FN_SEARCH,    32'sh7fffffff,    5'd0,  5'd1,  1'b0, NO_RES},
		'{FN_DEL_POS,   32'sd0,           5'd16, 5'd1,  1'b0, NO_RES},
		'{FN_DEL_BACK,  32'sd0,           5'd0,  5'd8,  1'b0, NO_RES},
		'{FN_DEL_FRONT, 32'sd0,           5'd0,  5'd7,  1'b0, NO_RES},
		'{FN_DEL_BACK,  32'sd0,           5'd0,  5'd1,  1'b1, EMPTY_RES}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [FUNC_W-1:0]       func;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;
	logic                    done;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] removed_value;
	logic [CNT_W-1:0]        match_count;
	logic [CNT_W-1:0]        length;

	logic signed [VAL_W-1:0] list_cells[LIST_DEPTH];
	int                      list_len;
	list_result_t            pending_results[$];
	list_result_t            fixed_res;
	list_result_t            want_res;
	list_result_t            model_res;
	logic                    hold_fixed;

	int mismatches;
	int commands_sent;
	int results_seen;
	int status_tally[4];
	int search_hits;
	logic signed [VAL_W-1:0] key_pool[4];

	positional_list_engine #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.position(position),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.match_count(match_count),
		.length(length)
	);

	always #5 clk = ~clk;

	function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] op,
		input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t r;
		int at;
		r = '0;
		at = -1;
		case (op)
			FN_INS_FRONT, FN_INS_POS, FN_INS_BACK: begin
				if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					if (op == FN_INS_FRONT || list_len == 0)
						at = 0;
					else if (op == FN_INS_BACK)
						at = list_len;
					else if (pos >= 1 && pos <= list_len + 1)
						at = pos - 1;
					if (at < 0) begin
						r.status = ST_RANGE;
					end else begin
						for (int k = list_len; k > at; k--)
							list_cells[k] = list_cells[k-1];
						list_cells[at] = val;
						list_len++;
					end
				end
			end
			FN_DEL_FRONT, FN_DEL_POS, FN_DEL_BACK: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (op == FN_DEL_FRONT)
						at = 0;
					else if (op == FN_DEL_BACK)
						at = list_len - 1;
					else if (pos >= 1 && pos <= list_len)
						at = pos - 1;
					if (at < 0) begin
						r.status = ST_RANGE;
					end else begin
						r.removed = list_cells[at];
						for (int k = at; k + 1 < list_len; k++)
							list_cells[k] = list_cells[k+1];
						list_len--;
					end
				end
			end
			FN_SEARCH: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int k = 0; k < list_len; k++)
						if (list_cells[k] == val)
							r.hits++;
				end
			end
			default: ;
		endcase
		r.len = list_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// result check first, then the transfer of a new command
	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				results_seen++;
				status_tally[status]++;
				if (match_count != 0)
					search_hits++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result with none pending, status=%0d length=%0d",
						status, length));
				end else begin
					want_res = pending_results.pop_front();
					if (status !== want_res.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want_res.status));
					if (removed_value !== want_res.removed)
						report_mismatch($sformatf("removed_value got %0d want %0d",
							removed_value, want_res.removed));
					if (match_count !== want_res.hits)
						report_mismatch($sformatf("match_count got %0d want %0d",
							match_count, want_res.hits));
					if (length !== want_res.len)
						report_mismatch($sformatf("length got %0d want %0d",
							length, want_res.len));
				end
			end
			if (start && !busy) begin
				model_res = apply_list_op(func, value, position);
				pending_results.push_back(hold_fixed ? fixed_res : model_res);
			end
		end
	end

	task automatic issue_cmd(input logic [FUNC_W-1:0] op, input logic signed [VAL_W-1:0] val,
		input logic [POS_W-1:0] pos, input logic fixed, input list_result_t res);
		@(negedge clk);
		start = 1'b1;
		func = op;
		value = val;
		position = pos;
		hold_fixed = fixed;
		fixed_res = res;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		commands_sent++;
	endtask

	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start = 1'b0;
			func = FUNC_W'($urandom);
			value = $urandom;
			position = POS_W'($urandom);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_cmd(input bit filling);
		logic [FUNC_W-1:0]       op;
		logic signed [VAL_W-1:0] val;
		logic [POS_W-1:0]        pos;
		int                      pick;
		pick = $urandom_range(99);
		if (pick < 5)
			op = FN_NOP;
		else if (pick < 20)
			op = FN_SEARCH;
		else if ((pick < 60) == filling)
			op = FUNC_W'(FN_INS_FRONT + $urandom_range(2));
		else
			op = FUNC_W'(FN_DEL_FRONT + $urandom_range(2));
		pick = $urandom_range(9);
		if (pick < 4)
			val = key_pool[$urandom_range(3)];
		else if (pick < 6 && list_len > 0)
			val = list_cells[$urandom_range(list_len - 1)];
		else if (pick == 6)
			val = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		else
			val = $urandom;
		if ($urandom_range(9) < 7)
			pos = POS_W'($urandom_range(list_len + 2));
		else
			pos = POS_W'($urandom);
		issue_cmd(op, val, pos, 1'b0, NO_RES);
	endtask

	initial begin
		int idle_pct[4];
		int gap_pct;
		bit filling;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_NOP;
		value = '0;
		position = '0;
		hold_fixed = 1'b0;
		fixed_res = '0;
		list_len = 0;
		mismatches = 0;
		commands_sent = 0;
		results_seen = 0;
		search_hits = 0;
		status_tally = '{0, 0, 0, 0};
		idle_pct = '{0, 47, 0, 30};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			for (int n = 0; n < DIRECTED[i].reps; n++)
				issue_cmd(DIRECTED[i].op, DIRECTED[i].val, DIRECTED[i].pos,
					DIRECTED[i].fixed, DIRECTED[i].res);

		filling = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			foreach (key_pool[j])
				key_pool[j] = $urandom_range(1) ? $urandom_range(7) : $urandom;
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				if (n % 40 == 0) begin
					filling = $urandom_range(1);
					gap_pct = ($urandom_range(3) == 0) ? 0 : idle_pct[ph];
				end
				sender_gap(gap_pct);
				random_cmd(filling);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("covered %0d commands and %0d results across four sender idle profiles",
			commands_sent, results_seen);
		$display("status ok/empty/range/full %0d/%0d/%0d/%0d, searches with matches %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3], search_hits);
		if (mismatches == 0)
			$display("tb_positional_list_engine passed");
		else
			$display("tb_positional_list_engine failed");
		$finish;
	end

	initial begin
		#3000000;
		$display("tb_positional_list_engine failed");
		$finish;
	end

endmodule
